// ===== src/dcag_pkg.sv =====
// Shared types and constants for the duty-cycle audio gate.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package dcag_pkg;

  // Word format
  localparam int SAMPLE_W   = 24;
  localparam int GAIN_W     = 31;
  localparam int INC_W      = 32;
  localparam int RAMP_W     = 20;
  localparam int PHASE_W    = 32;
  localparam int CHANNELS   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Q1.30 unity gain
  localparam logic [GAIN_W-1:0] GAIN_ONE = 31'h4000_0000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_THR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_LEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_EN    = 3'd3;

  // Reset values of the registers
  localparam logic [PHASE_W-1:0] RST_PHASE_STEP = 32'd4474;
  localparam logic [PHASE_W-1:0] RST_DUTY_THR   = 32'd3221225472;
  localparam logic [RAMP_W-1:0]  RST_RAMP_LEN   = 20'd48000;

  // Request to the ramp-increment divider
  typedef struct packed {
    logic                start;
    logic                neg;
    logic [GAIN_W-1:0]   mag;
    logic [RAMP_W-1:0]   divisor;
  } div_req_t;

  // Answer from the divider
  typedef struct packed {
    logic                    done;
    logic signed [INC_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== src/dcag_div.sv =====
// Restoring divider, one quotient bit per cycle, for the ramp increment.
// Depends on dcag_pkg.
`timescale 1ns / 1ps
module dcag_div (
  input  logic              clk,
  input  logic              rst_n,
  input  dcag_pkg::div_req_t req,
  output dcag_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(dcag_pkg::GAIN_W);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic                           neg_r, neg_nxt;
  logic [dcag_pkg::RAMP_W-1:0]    dvs_r, dvs_nxt;
  logic [dcag_pkg::RAMP_W-1:0]    rem_r, rem_nxt;
  logic [dcag_pkg::GAIN_W-1:0]    qd_r, qd_nxt;   // dividend out at top, quotient in at bottom
  logic [dcag_pkg::RAMP_W:0]      rem_sh;
  logic [dcag_pkg::RAMP_W:0]      rem_sub;

  // One restoring step
  assign rem_sh  = {rem_r, qd_r[dcag_pkg::GAIN_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    qd_nxt   = qd_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(dcag_pkg::GAIN_W - 1);
      neg_nxt  = req.neg;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
      qd_nxt   = req.mag;
    end else if (busy_r) begin
      if (!rem_sub[dcag_pkg::RAMP_W]) begin
        rem_nxt = rem_sub[dcag_pkg::RAMP_W-1:0];
        qd_nxt  = {qd_r[dcag_pkg::GAIN_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[dcag_pkg::RAMP_W-1:0];
        qd_nxt  = {qd_r[dcag_pkg::GAIN_W-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
    qd_r  <= qd_nxt;
  end

  // Truncation toward zero: negate the magnitude quotient
  assign rsp.done = done_r;
  assign rsp.quot = neg_r ? -$signed({1'b0, qd_r}) : $signed({1'b0, qd_r});

endmodule

// ===== src/dcag_lane.sv =====
// One channel lane: Q1.23 sample times Q1.30 gain, floor to Q1.23 or pass through, registered.
// Depends on dcag_pkg.
`timescale 1ns / 1ps
module dcag_lane (
  input  logic                                 clk,
  input  logic                                 load,
  input  logic                                 enable,
  input  logic signed [dcag_pkg::SAMPLE_W-1:0] sample,
  input  logic        [dcag_pkg::GAIN_W-1:0]   gain,
  output logic signed [dcag_pkg::SAMPLE_W-1:0] result
);

  localparam int PROD_W = dcag_pkg::SAMPLE_W + dcag_pkg::GAIN_W + 1;

  logic signed [PROD_W-1:0]             prod;
  logic signed [dcag_pkg::SAMPLE_W-1:0] res_r, res_nxt;

  // Arithmetic shift by 30 is the floor; the low 24 bits are the word
  assign prod = sample * $signed({1'b0, gain});

  always_comb begin
    res_nxt = res_r;
    if (load) begin
      res_nxt = enable ? prod[dcag_pkg::SAMPLE_W+29:30] : sample;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign result = res_r;

endmodule

// ===== src/duty_cycle_audio_gate.sv =====
// Top level of the duty-cycle audio gate: config registers, LFO, gain ramp.
// Depends on dcag_pkg, dcag_div and dcag_lane.
`timescale 1ns / 1ps
// One stereo word in, one gated word out. A word goes from acceptance
// through the ramp, multiply and output steps to the output register; when
// the square LFO changes level and a ramp of nonzero length starts, the
// divide step comes first: the ramp increment comes from a restoring divider
// that yields one quotient bit per cycle. Words are handled one at a time; a finished word waits
// in the output register while the next word is taken. The gain is Q1.30
// and each output is floor(sample * gain / 2^30); with gate_enable at 0
// the samples pass unchanged. Configuration writes are taken at any time
// but are meant for when the block is idle.
module duty_cycle_audio_gate (
  input  logic                                      clk,
  input  logic                                      rst_n,
  // input channel
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic signed [dcag_pkg::SAMPLE_W-1:0]      in_sample_left,
  input  logic signed [dcag_pkg::SAMPLE_W-1:0]      in_sample_right,
  // result channel
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [dcag_pkg::SAMPLE_W-1:0]      out_left,
  output logic signed [dcag_pkg::SAMPLE_W-1:0]      out_right,
  // configuration
  input  logic                                      cfg_we,
  input  logic [dcag_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [dcag_pkg::CFG_DATA_W-1:0]           cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_RAMP = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam int SUM_W = dcag_pkg::INC_W + 1;

  // Configuration registers
  logic [dcag_pkg::PHASE_W-1:0] phase_step_r, phase_step_nxt;
  logic [dcag_pkg::PHASE_W-1:0] duty_thr_r, duty_thr_nxt;
  logic [dcag_pkg::RAMP_W-1:0]  ramp_len_r, ramp_len_nxt;
  logic                         gate_en_r, gate_en_nxt;

  // Gate state
  logic [2:0]                          state_r, state_nxt;
  logic [dcag_pkg::PHASE_W-1:0]        phase_r, phase_nxt;
  logic [dcag_pkg::GAIN_W-1:0]         gain_r, gain_nxt;
  logic                                tgt_r, tgt_nxt;
  logic signed [dcag_pkg::INC_W-1:0]   inc_r, inc_nxt;
  logic [dcag_pkg::RAMP_W-1:0]         rem_r, rem_nxt;
  logic signed [dcag_pkg::SAMPLE_W-1:0] samp_r [dcag_pkg::CHANNELS];
  logic signed [dcag_pkg::SAMPLE_W-1:0] samp_nxt [dcag_pkg::CHANNELS];
  logic signed [dcag_pkg::SAMPLE_W-1:0] in_samp [dcag_pkg::CHANNELS];
  logic signed [dcag_pkg::SAMPLE_W-1:0] lane_res [dcag_pkg::CHANNELS];

  // Output register
  logic                                out_valid_r, out_valid_nxt;
  logic signed [dcag_pkg::SAMPLE_W-1:0] out_r [dcag_pkg::CHANNELS];
  logic signed [dcag_pkg::SAMPLE_W-1:0] out_nxt [dcag_pkg::CHANNELS];

  logic                          in_acc;
  logic                          tgt_now;
  logic                          out_load;
  logic                          lane_load;
  logic [dcag_pkg::GAIN_W-1:0]   tgt_full;
  logic [dcag_pkg::RAMP_W-1:0]   rem_dec;
  logic signed [SUM_W-1:0]       gain_sum;
  dcag_pkg::div_req_t            div_req;
  dcag_pkg::div_rsp_t            div_rsp;

  assign in_samp[0] = in_sample_left;
  assign in_samp[1] = in_sample_right;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign tgt_now   = (phase_r <= duty_thr_r);
  assign tgt_full  = tgt_r ? dcag_pkg::GAIN_ONE : '0;
  assign rem_dec   = rem_r - 1'b1;
  assign gain_sum  = $signed({2'b00, gain_r}) + $signed({inc_r[dcag_pkg::INC_W-1], inc_r});
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign lane_load = (state_r == S_MUL);

  // Divider request: start a ramp when the level flips and the length is nonzero
  always_comb begin
    div_req.start   = in_acc && (tgt_now != tgt_r) && (ramp_len_r != '0);
    div_req.neg     = !tgt_now;
    div_req.mag     = tgt_now ? (dcag_pkg::GAIN_ONE - gain_r) : gain_r;
    div_req.divisor = ramp_len_r;
  end

  dcag_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Configuration writes
  always_comb begin
    phase_step_nxt = phase_step_r;
    duty_thr_nxt   = duty_thr_r;
    ramp_len_nxt   = ramp_len_r;
    gate_en_nxt    = gate_en_r;
    if (cfg_we) begin
      case (cfg_index)
        dcag_pkg::REG_PHASE_STEP: phase_step_nxt = cfg_wdata;
        dcag_pkg::REG_DUTY_THR:   duty_thr_nxt   = cfg_wdata;
        dcag_pkg::REG_RAMP_LEN:   ramp_len_nxt   = cfg_wdata[dcag_pkg::RAMP_W-1:0];
        dcag_pkg::REG_GATE_EN:    gate_en_nxt    = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Sequencer: level pick, increment divide, ramp step, lane multiply, output
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    gain_nxt  = gain_r;
    tgt_nxt   = tgt_r;
    inc_nxt   = inc_r;
    rem_nxt   = rem_r;
    for (int i = 0; i < dcag_pkg::CHANNELS; i++) begin
      samp_nxt[i] = samp_r[i];
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          for (int i = 0; i < dcag_pkg::CHANNELS; i++) begin
            samp_nxt[i] = in_samp[i];
          end
          phase_nxt = phase_r + phase_step_r;
          state_nxt = S_RAMP;
          if (tgt_now != tgt_r) begin
            tgt_nxt = tgt_now;
            rem_nxt = ramp_len_r;
            if (ramp_len_r == '0) begin
              gain_nxt = tgt_now ? dcag_pkg::GAIN_ONE : '0;
            end else begin
              state_nxt = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          inc_nxt   = div_rsp.quot;
          state_nxt = S_RAMP;
        end
      end
      S_RAMP: begin
        if (rem_r == '0) begin
          gain_nxt = tgt_full;
        end else begin
          rem_nxt = rem_dec;
          if (rem_dec != '0) begin
            if (gain_sum[SUM_W-1]) begin
              gain_nxt = '0;
            end else if (gain_sum > $signed({2'b00, dcag_pkg::GAIN_ONE})) begin
              gain_nxt = dcag_pkg::GAIN_ONE;
            end else begin
              gain_nxt = gain_sum[dcag_pkg::GAIN_W-1:0];
            end
          end else begin
            gain_nxt = tgt_full;
          end
        end
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Channel lanes
  for (genvar g = 0; g < dcag_pkg::CHANNELS; g++) begin : g_lane
    dcag_lane u_lane (
      .clk    (clk),
      .load   (lane_load),
      .enable (gate_en_r),
      .sample (samp_r[g]),
      .gain   (gain_r),
      .result (lane_res[g])
    );
  end

  // Merge lane results into the output word
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    for (int i = 0; i < dcag_pkg::CHANNELS; i++) begin
      out_nxt[i] = out_load ? lane_res[i] : out_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= dcag_pkg::RST_PHASE_STEP;
      duty_thr_r   <= dcag_pkg::RST_DUTY_THR;
      ramp_len_r   <= dcag_pkg::RST_RAMP_LEN;
      gate_en_r    <= 1'b1;
      state_r      <= S_IDLE;
      phase_r      <= '0;
      gain_r       <= '0;
      tgt_r        <= 1'b0;
      inc_r        <= '0;
      rem_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_step_r <= phase_step_nxt;
      duty_thr_r   <= duty_thr_nxt;
      ramp_len_r   <= ramp_len_nxt;
      gate_en_r    <= gate_en_nxt;
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      gain_r       <= gain_nxt;
      tgt_r        <= tgt_nxt;
      inc_r        <= inc_nxt;
      rem_r        <= rem_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    for (int i = 0; i < dcag_pkg::CHANNELS; i++) begin
      samp_r[i] <= samp_nxt[i];
      out_r[i]  <= out_nxt[i];
    end
  end

  assign out_valid = out_valid_r;
  assign out_left  = out_r[0];
  assign out_right = out_r[1];

`ifndef ASSERT_OFF
  // Gain stays within 0..1.0
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r <= dcag_pkg::GAIN_ONE)
    else $error("gain above unity");

  // With no ramp in flight, the gain sits on the current level
  a_gain_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && (rem_r == '0) |-> (gain_r == tgt_full))
    else $error("gain off target with no ramp pending");

  // The divider only reports while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide step");

  // Result goes out only from the output step
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && (state_r == S_IDLE))
    else $error("output load did not show a word");
`endif

endmodule
